// ===== rtl/core/ow_pkg.sv =====
// Shared types, timing constants and helpers of the single-wire bus master.
package ow_pkg;

    // Timer width in microsecond ticks
    localparam int TIMER_W = 9;

    // Bus reset low time in microseconds (1 to 511)
    localparam int RESET_LOW_TIME = 480;

    // Reset low load value; a zero load is forced to one tick
    localparam logic [TIMER_W-1:0] RESET_LOW_LOAD =
        ((RESET_LOW_TIME % (1 << TIMER_W)) == 0) ? TIMER_W'(1)
                                                  : TIMER_W'(RESET_LOW_TIME % (1 << TIMER_W));

    // Phase durations in microseconds
    localparam logic [TIMER_W-1:0] RESET_HIGH_TIME = 9'd480;
    localparam logic [TIMER_W-1:0] W1_LOW_TIME     = 9'd6;
    localparam logic [TIMER_W-1:0] W1_HIGH_TIME    = 9'd64;
    localparam logic [TIMER_W-1:0] W0_LOW_TIME     = 9'd60;
    localparam logic [TIMER_W-1:0] W0_HIGH_TIME    = 9'd10;
    localparam logic [TIMER_W-1:0] RD_LOW_TIME     = 9'd6;
    localparam logic [TIMER_W-1:0] RD_MID_TIME     = 9'd9;
    localparam logic [TIMER_W-1:0] RD_TAIL_TIME    = 9'd55;

    // Last bit position of a byte
    localparam logic [2:0] LAST_BIT = 3'd7;

    // Input item kinds
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Bus sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RST_LO  = 3'd1,
        PH_RST_HI  = 3'd2,
        PH_WR_LO   = 3'd3,
        PH_WR_HI   = 3'd4,
        PH_RD_LO   = 3'd5,
        PH_RD_MID  = 3'd6,
        PH_RD_TAIL = 3'd7
    } phase_t;

    // Line is pulled low in every low phase
    function automatic logic drives_low(input phase_t ph);
        return (ph == PH_RST_LO) || (ph == PH_WR_LO) || (ph == PH_RD_LO);
    endfunction

endpackage

// ===== rtl/core/one_wire_bus_master_top.sv =====
// Single-wire open-drain bus master: tick-timed reset, byte write and byte read sequencer.

// Every input transfer is either a one-microsecond tick or a command (bus reset, write byte,
// read byte) and yields exactly one result transfer that shows the bus phase reached after
// that item: line drive, busy, the byte of the last completed read and a done flag on the
// tick that ends an operation. The sequencer state and the output register are both loaded
// from the accepted item at the same clock edge; the block takes one
// item per clock, and keeps accepting while a result is held as long as the output register
// is taken in the same cycle. A command seen while busy is dropped; the running operation
// goes on. Line level is sampled from the tick that ends the nine microsecond read window.
module one_wire_bus_master_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] line_level, [15:9] zero
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] line_drive_low, [1] busy_res,
                                   // [9:2] received_byte, [10] done_res, [15:11] zero
);
    import ow_pkg::*;

    phase_t             phase_reg,  phase_next;
    logic [TIMER_W-1:0] timer_reg,  timer_next;
    logic [2:0]         bit_reg,    bit_next;
    logic [7:0]         shift_reg,  shift_next;
    logic [7:0]         rx_reg,     rx_next;
    logic               done_next;

    logic               m_valid_reg;
    logic [15:0]        m_data_reg,  m_data_next;

    logic               accept;
    op_t                op_in;
    logic [7:0]         data_in;
    logic               level_in;

    // Unpack the input transfer
    assign op_in    = op_t'(s_tuser);
    assign data_in  = s_tdata[7:0];
    assign level_in = s_tdata[8];

    // Take a new item whenever the output register is free or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Sequencer next state
    always_comb begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        rx_next    = rx_reg;
        done_next  = 1'b0;
        if (accept) begin
            if (op_in == OP_TICK) begin
                if (phase_reg != PH_IDLE) begin
                    if (timer_reg <= TIMER_W'(1)) begin
                        // current phase expires: move to the next one
                        unique case (phase_reg)
                            PH_RST_LO: begin
                                phase_next = PH_RST_HI;
                                timer_next = RESET_HIGH_TIME;
                            end
                            PH_RST_HI: begin
                                phase_next = PH_IDLE;
                                timer_next = '0;
                                done_next  = 1'b1;
                            end
                            PH_WR_LO: begin
                                phase_next = PH_WR_HI;
                                timer_next = shift_reg[0] ? W1_HIGH_TIME : W0_HIGH_TIME;
                            end
                            PH_WR_HI: begin
                                shift_next = {1'b0, shift_reg[7:1]};
                                if (bit_reg == LAST_BIT) begin
                                    bit_next   = '0;
                                    phase_next = PH_IDLE;
                                    timer_next = '0;
                                    done_next  = 1'b1;
                                end else begin
                                    bit_next   = bit_reg + 3'd1;
                                    phase_next = PH_WR_LO;
                                    timer_next = shift_reg[1] ? W1_LOW_TIME : W0_LOW_TIME;
                                end
                            end
                            PH_RD_LO: begin
                                phase_next = PH_RD_MID;
                                timer_next = RD_MID_TIME;
                            end
                            PH_RD_MID: begin
                                shift_next = {level_in, shift_reg[7:1]};
                                phase_next = PH_RD_TAIL;
                                timer_next = RD_TAIL_TIME;
                            end
                            PH_RD_TAIL: begin
                                if (bit_reg == LAST_BIT) begin
                                    bit_next   = '0;
                                    rx_next    = shift_reg;
                                    phase_next = PH_IDLE;
                                    timer_next = '0;
                                    done_next  = 1'b1;
                                end else begin
                                    bit_next   = bit_reg + 3'd1;
                                    phase_next = PH_RD_LO;
                                    timer_next = RD_LOW_TIME;
                                end
                            end
                            default: begin
                                phase_next = PH_IDLE;
                                timer_next = '0;
                            end
                        endcase
                    end else begin
                        timer_next = timer_reg - TIMER_W'(1);
                    end
                end
            end else if (phase_reg == PH_IDLE) begin
                // start a command; commands while busy are dropped
                bit_next = '0;
                unique case (op_in)
                    OP_RESET: begin
                        phase_next = PH_RST_LO;
                        timer_next = RESET_LOW_LOAD;
                    end
                    OP_WRITE: begin
                        shift_next = data_in;
                        phase_next = PH_WR_LO;
                        timer_next = data_in[0] ? W1_LOW_TIME : W0_LOW_TIME;
                    end
                    default: begin
                        shift_next = '0;
                        phase_next = PH_RD_LO;
                        timer_next = RD_LOW_TIME;
                    end
                endcase
            end
        end
    end

    // Result word from the phase reached after the item
    always_comb begin
        m_data_next        = '0;
        m_data_next[0]     = drives_low(phase_next);
        m_data_next[1]     = (phase_next != PH_IDLE);
        m_data_next[9:2]   = rx_next;
        m_data_next[10]    = done_next;
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            rx_reg    <= '0;
        end else begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            rx_reg    <= rx_next;
        end
    end

    // Output register: load on accept, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A finished operation never reports busy in the same result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[10]) |-> !m_data_reg[1])
        else $error("done result still shows busy");

    // A command accepted while idle always starts a phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op_in != OP_TICK && phase_reg == PH_IDLE) |=> (phase_reg != PH_IDLE))
        else $error("command did not start an operation");

    // A busy phase always has time left on its timer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> (timer_reg != '0))
        else $error("busy phase with empty timer");

    // Bit position moves only during byte slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        (bit_reg != '0) |-> (phase_reg == PH_WR_LO || phase_reg == PH_WR_HI ||
                             phase_reg == PH_RD_LO || phase_reg == PH_RD_MID ||
                             phase_reg == PH_RD_TAIL))
        else $error("bit index set outside a byte transfer");

endmodule
